// File: src/bba_pkg.sv
// Shared types and codes of the buddy block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bba_pkg;

   typedef enum logic [1:0] {
      NODE_ABSENT,
      NODE_FREE,
      NODE_USED,
      NODE_SPLIT
   } node_state_type;

   localparam logic [1:0] RSP_OK        = 2'd0;
   localparam logic [1:0] RSP_FULL      = 2'd1;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_SREAD,
      S_SCHECK,
      S_SPLIT,
      S_SPLIT2,
      S_FREAD,
      S_FCHECK,
      S_MREAD,
      S_MCHECK,
      S_MABS,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_READ_ALLOC,
      OP_SCAN_NEXT,
      OP_SPLIT_SELF,
      OP_SPLIT_RIGHT,
      OP_MARK_USED,
      OP_READ_FREE,
      OP_DESCEND,
      OP_FREE_FOUND,
      OP_READ_BUDDY,
      OP_WRITE_FREE,
      OP_ABSENT_SELF,
      OP_ABSENT_BUDDY,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic [1:0] node;
      logic       bad;
      logic       lv_zero;
      logic       lv_lt_d;
      logic       lv_at_max;
      logic       pos_last;
      logic       aligned;
      logic       clr_done;
      logic       rsp_full;
   } dp_status_type;

endpackage

// File: src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 511
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bba_datapath.sv
// Datapath of the buddy block allocator: tree memory, level and position
// registers, free byte count and result registers. Uses bba_pkg and bba_ram.
module bba_datapath #(
   parameter int PAGE_LOG2      = 16,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bba_pkg::dp_op_type    op,
   input  logic                  rsp_taken,
   input  logic                  req_mode,
   input  logic [16:0]           req_request_size,
   input  logic [15:0]           req_block_offset,
   output bba_pkg::dp_status_type st,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_granted_offset,
   output logic [16:0]           rsp_free_bytes
);

   localparam int MINB       = (MIN_BLOCK_LOG2 < PAGE_LOG2) ? MIN_BLOCK_LOG2 : PAGE_LOG2;
   localparam int LEVELS     = PAGE_LOG2 - MINB;
   localparam int NODE_COUNT = (2 << LEVELS) - 1;
   localparam int AW         = LEVELS + 1;
   localparam int POSW       = LEVELS + 1;
   localparam int LW         = $clog2(LEVELS + 2);
   localparam int KW         = $clog2(PAGE_LOG2 + 1);
   localparam int FCW        = PAGE_LOG2 + 1;

   logic [LW-1:0]   lv_ff, lv_in, d_ff, d_in;
   logic [POSW-1:0] pos_ff, pos_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [15:0]     off_ff, off_in;
   logic            bad_ff, bad_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [FCW-1:0]  fc_ff, fc_in;
   logic [1:0]      res_status_ff, res_status_in;
   logic [15:0]     res_offset_ff, res_offset_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [15:0]     rsp_offset_ff, rsp_offset_in;
   logic [16:0]     rsp_free_ff, rsp_free_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [1:0]      wr_data, rd_data;
   logic [5:0]      sh;
   logic [POSW-1:0] off_pos;
   logic [16:0]     size1;
   logic [16:0]     sm1;
   int              kc;

   function automatic logic [AW-1:0] node_index(input logic [LW-1:0] lv,
                                                input logic [POSW-1:0] pos);
      node_index = AW'((AW'(1) << lv) - AW'(1)) + AW'(pos);
   endfunction

   bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sh      = 6'(PAGE_LOG2) - 6'(lv_ff);
   assign off_pos = POSW'(32'(off_ff) >> sh);
   assign size1   = (req_request_size == 17'd0) ? 17'd1 : req_request_size;
   assign sm1     = size1 - 17'd1;

   always_comb begin
      kc = 0;
      for (int i = 0; i < 17; i++) begin
         if (sm1[i]) begin
            kc = i + 1;
         end
      end
      if (kc < MINB) begin
         kc = MINB;
      end
   end

   always_comb begin
      lv_in         = lv_ff;
      d_in          = d_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      off_in        = off_ff;
      bad_in        = bad_ff;
      clr_in        = clr_ff;
      fc_in         = fc_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_valid_ff;
      wr_en         = 1'b0;
      wr_addr       = node_index(lv_ff, pos_ff);
      wr_data       = bba_pkg::NODE_ABSENT;
      rd_addr       = node_index(lv_ff, pos_ff);
      case (op)
         bba_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0) ? bba_pkg::NODE_FREE : bba_pkg::NODE_ABSENT;
            clr_in  = clr_ff + AW'(1);
         end
         bba_pkg::OP_LOAD: begin
            k_in          = KW'(kc);
            d_in          = LW'(PAGE_LOG2 - kc);
            off_in        = req_block_offset;
            pos_in        = '0;
            lv_in         = req_mode ? '0 : LW'(PAGE_LOG2 - kc);
            bad_in        = req_mode ? (32'(req_block_offset) >= (32'd1 << PAGE_LOG2))
                                     : (32'(size1) > (32'd1 << PAGE_LOG2));
            res_status_in = req_mode ? bba_pkg::RSP_NOT_FOUND : bba_pkg::RSP_FULL;
            res_offset_in = '0;
         end
         bba_pkg::OP_READ_ALLOC: begin
            rd_addr = node_index(lv_ff, pos_ff);
         end
         bba_pkg::OP_SCAN_NEXT: begin
            if (st.pos_last) begin
               lv_in  = lv_ff - LW'(1);
               pos_in = '0;
            end else begin
               pos_in = pos_ff + POSW'(1);
            end
         end
         bba_pkg::OP_SPLIT_SELF: begin
            wr_en   = 1'b1;
            wr_data = bba_pkg::NODE_SPLIT;
         end
         bba_pkg::OP_SPLIT_RIGHT: begin
            wr_en   = 1'b1;
            wr_addr = node_index(lv_ff + LW'(1), {pos_ff[POSW-2:0], 1'b1});
            wr_data = bba_pkg::NODE_FREE;
            lv_in   = lv_ff + LW'(1);
            pos_in  = {pos_ff[POSW-2:0], 1'b0};
         end
         bba_pkg::OP_MARK_USED: begin
            wr_en         = 1'b1;
            wr_data       = bba_pkg::NODE_USED;
            fc_in         = fc_ff - (FCW'(1) << k_ff);
            res_status_in = bba_pkg::RSP_OK;
            res_offset_in = 16'(32'(pos_ff) << k_ff);
         end
         bba_pkg::OP_READ_FREE: begin
            rd_addr = node_index(lv_ff, off_pos);
            pos_in  = off_pos;
         end
         bba_pkg::OP_DESCEND: begin
            lv_in = lv_ff + LW'(1);
         end
         bba_pkg::OP_FREE_FOUND: begin
            fc_in         = fc_ff + (FCW'(1) << sh);
            res_status_in = bba_pkg::RSP_OK;
            res_offset_in = '0;
         end
         bba_pkg::OP_READ_BUDDY: begin
            rd_addr = node_index(lv_ff, pos_ff ^ POSW'(1));
         end
         bba_pkg::OP_WRITE_FREE: begin
            wr_en   = 1'b1;
            wr_data = bba_pkg::NODE_FREE;
         end
         bba_pkg::OP_ABSENT_SELF: begin
            wr_en   = 1'b1;
            wr_data = bba_pkg::NODE_ABSENT;
         end
         bba_pkg::OP_ABSENT_BUDDY: begin
            wr_en   = 1'b1;
            wr_addr = node_index(lv_ff, pos_ff ^ POSW'(1));
            wr_data = bba_pkg::NODE_ABSENT;
            lv_in   = lv_ff - LW'(1);
            pos_in  = pos_ff >> 1;
         end
         bba_pkg::OP_EMIT: begin
            rsp_status_in = res_status_ff;
            rsp_offset_in = res_offset_ff;
            rsp_free_in   = 17'(fc_ff);
         end
         default: begin
         end
      endcase
      if (op == bba_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         fc_ff        <= FCW'(1) << PAGE_LOG2;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         fc_ff        <= fc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lv_ff         <= lv_in;
      d_ff          <= d_in;
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      off_ff        <= off_in;
      bad_ff        <= bad_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign st.node      = rd_data;
   assign st.bad       = bad_ff;
   assign st.lv_zero   = (lv_ff == '0);
   assign st.lv_lt_d   = (lv_ff < d_ff);
   assign st.lv_at_max = (lv_ff == LW'(LEVELS));
   assign st.pos_last  = (pos_ff == POSW'((POSW'(1) << lv_ff) - POSW'(1)));
   assign st.aligned   = ((32'(pos_ff) << sh) == 32'(off_ff));
   assign st.clr_done  = (clr_ff == AW'(NODE_COUNT - 1));
   assign st.rsp_full  = rsp_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_offset_ff;
   assign rsp_free_bytes     = rsp_free_ff;

endmodule

// File: src/bba_ctrl.sv
// Controller state machine of the buddy block allocator.
// Uses bba_pkg; drives the datapath through one operation code per cycle.
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  bba_pkg::dp_status_type st,
   output bba_pkg::dp_op_type     op,
   output logic                   rsp_taken
);

   bba_pkg::ctrl_state_type state_ff, state_in;
   logic                    mode_ff, mode_in;

   logic node_free, node_used, node_split;
   assign node_free  = (st.node == bba_pkg::NODE_FREE);
   assign node_used  = (st.node == bba_pkg::NODE_USED);
   assign node_split = (st.node == bba_pkg::NODE_SPLIT);
   assign rsp_taken  = st.rsp_full && rsp_ready;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (st.clr_done) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               state_in = bba_pkg::S_START;
            end
         end
         bba_pkg::S_START: begin
            if (st.bad) begin
               state_in = bba_pkg::S_DONE;
            end else if (mode_ff) begin
               state_in = bba_pkg::S_FREAD;
            end else begin
               state_in = bba_pkg::S_SREAD;
            end
         end
         bba_pkg::S_SREAD: begin
            state_in = bba_pkg::S_SCHECK;
         end
         bba_pkg::S_SCHECK: begin
            if (node_free) begin
               state_in = bba_pkg::S_SPLIT;
            end else if (st.pos_last && st.lv_zero) begin
               state_in = bba_pkg::S_DONE;
            end else begin
               state_in = bba_pkg::S_SREAD;
            end
         end
         bba_pkg::S_SPLIT: begin
            state_in = st.lv_lt_d ? bba_pkg::S_SPLIT2 : bba_pkg::S_DONE;
         end
         bba_pkg::S_SPLIT2: begin
            state_in = bba_pkg::S_SPLIT;
         end
         bba_pkg::S_FREAD: begin
            state_in = bba_pkg::S_FCHECK;
         end
         bba_pkg::S_FCHECK: begin
            if (node_used && st.aligned) begin
               state_in = bba_pkg::S_MREAD;
            end else if (!node_split || st.lv_at_max) begin
               state_in = bba_pkg::S_DONE;
            end else begin
               state_in = bba_pkg::S_FREAD;
            end
         end
         bba_pkg::S_MREAD: begin
            state_in = st.lv_zero ? bba_pkg::S_DONE : bba_pkg::S_MCHECK;
         end
         bba_pkg::S_MCHECK: begin
            state_in = node_free ? bba_pkg::S_MABS : bba_pkg::S_DONE;
         end
         bba_pkg::S_MABS: begin
            state_in = bba_pkg::S_MREAD;
         end
         bba_pkg::S_DONE: begin
            if (!st.rsp_full || rsp_ready) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      op        = bba_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            op = bba_pkg::OP_CLEAR;
         end
         bba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = bba_pkg::OP_LOAD;
            end
         end
         bba_pkg::S_SREAD: begin
            op = bba_pkg::OP_READ_ALLOC;
         end
         bba_pkg::S_SCHECK: begin
            if (!node_free && !(st.pos_last && st.lv_zero)) begin
               op = bba_pkg::OP_SCAN_NEXT;
            end
         end
         bba_pkg::S_SPLIT: begin
            op = st.lv_lt_d ? bba_pkg::OP_SPLIT_SELF : bba_pkg::OP_MARK_USED;
         end
         bba_pkg::S_SPLIT2: begin
            op = bba_pkg::OP_SPLIT_RIGHT;
         end
         bba_pkg::S_FREAD: begin
            op = bba_pkg::OP_READ_FREE;
         end
         bba_pkg::S_FCHECK: begin
            if (node_used && st.aligned) begin
               op = bba_pkg::OP_FREE_FOUND;
            end else if (node_split && !st.lv_at_max) begin
               op = bba_pkg::OP_DESCEND;
            end
         end
         bba_pkg::S_MREAD: begin
            op = st.lv_zero ? bba_pkg::OP_WRITE_FREE : bba_pkg::OP_READ_BUDDY;
         end
         bba_pkg::S_MCHECK: begin
            op = node_free ? bba_pkg::OP_ABSENT_SELF : bba_pkg::OP_WRITE_FREE;
         end
         bba_pkg::S_MABS: begin
            op = bba_pkg::OP_ABSENT_BUDDY;
         end
         bba_pkg::S_DONE: begin
            if (!st.rsp_full || rsp_ready) begin
               op = bba_pkg::OP_EMIT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
   end

endmodule

// File: src/buddy_block_allocator.sv
// Buddy allocator for one page of 2^PAGE_LOG2 bytes in blocks of at least
// 2^MIN_BLOCK_LOG2 bytes. After reset the block clears the node memory, all
// 2^(LEVELS+1)-1 tree nodes (511 at the defaults), and accepts no item until
// that is done. An allocate item inspects tree nodes on its way from the wanted
// level toward the root until it finds a free one, then splits that block down
// to the wanted level and marks it used; one that finds no free block or is
// oversize goes straight to the result. Each node check takes a read state and
// a check state because the node memory has a registered read. A free item
// descends from the root level by level until it finds its block, frees it and
// merges it with free buddies toward the root. Emitting waits while the
// previous result is still not taken. One item is worked on at a time; the next
// item is taken while the previous result still waits in the output register.
// Uses bba_pkg, bba_ctrl, bba_datapath and bba_ram.
module buddy_block_allocator #(
   parameter int PAGE_LOG2      = 16,
   parameter int MIN_BLOCK_LOG2 = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_block_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_offset,
   output logic [16:0] rsp_free_bytes
);

   bba_pkg::dp_op_type     op;
   bba_pkg::dp_status_type st;
   logic                   rsp_taken;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .st        (st),
      .op        (op),
      .rsp_taken (rsp_taken)
   );

   bba_datapath #(
      .PAGE_LOG2      (PAGE_LOG2),
      .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .rsp_taken          (rsp_taken),
      .req_mode           (req_mode),
      .req_request_size   (req_request_size),
      .req_block_offset   (req_block_offset),
      .st                 (st),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_free_bytes     (rsp_free_bytes)
   );

endmodule
